// File: hdl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants of the buddy page allocator
// Page kinds, status codes, channel beats and the memory port bundles.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int NUM_ORDERS = 13;
  localparam int AW = 12;  // page address into the stores
  localparam int PW = 13;  // page index plus the empty-list mark
  localparam int OW = 4;   // block order
  localparam int SW = 6;   // sequencer state

  localparam logic [PW-1:0] NIL     = PW'(NUM_PAGES);
  localparam logic [OW-1:0] ORD_MAX = OW'(NUM_ORDERS - 1);

  typedef enum logic [2:0] {
    KIND_FREE     = 3'd0,
    KIND_NOT_HEAD = 3'd1,
    KIND_ALLOC    = 3'd2,
    KIND_PAIR     = 3'd3,
    KIND_RESERVED = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOMEM    = 3'd1,
    ST_DOUBLE   = 3'd2,
    ST_NOT_HEAD = 3'd3,
    ST_BAD_PAIR = 3'd4
  } status_e;

  typedef struct packed {
    kind_e         kind;
    logic [OW-1:0] order;
  } meta_t;

  typedef struct packed {
    logic          action;
    logic [12:0]   page_count;
    logic [AW-1:0] page;
  } in_t;

  typedef struct packed {
    logic [AW-1:0] start_page;
    logic [2:0]    status;
    logic [12:0]   free_pages;
  } out_t;

  typedef struct packed {
    logic          meta_we;
    logic [AW-1:0] meta_waddr;
    meta_t         meta_wdata;
    logic [AW-1:0] meta_raddr;
    logic          next_we;
    logic [AW-1:0] next_waddr;
    logic [PW-1:0] next_wdata;
    logic [AW-1:0] next_raddr;
    logic          prev_we;
    logic [AW-1:0] prev_waddr;
    logic [PW-1:0] prev_wdata;
    logic [AW-1:0] prev_raddr;
  } mem_req_t;

  typedef struct packed {
    meta_t         meta;
    logic [PW-1:0] next;
    logic [PW-1:0] prev;
  } mem_rsp_t;

endpackage

// File: hdl/bpa_store.sv
// ----------------------------------------------------------------------------
// bpa_store: per-page stores
// Page kind/order, next link and prev link, one write and one registered
// read port each. After reset a sweep marks every page reserved, order 0.
// ----------------------------------------------------------------------------
module bpa_store import bpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output mem_rsp_t rsp_o,
  output logic     clr_busy_o
);

  meta_t         meta_mem [NUM_PAGES];
  logic [PW-1:0] next_mem [NUM_PAGES];
  logic [PW-1:0] prev_mem [NUM_PAGES];

  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  // clearing sweep, one page a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(NUM_PAGES - 1)) clr_busy_q <= 1'b0;
    end
  end

  // kind/order store and link stores
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      meta_mem[clr_addr_q] <= '{kind: KIND_RESERVED, order: '0};
    end else if (req_i.meta_we) begin
      meta_mem[req_i.meta_waddr] <= req_i.meta_wdata;
    end
    if (req_i.next_we) next_mem[req_i.next_waddr] <= req_i.next_wdata;
    if (req_i.prev_we) prev_mem[req_i.prev_waddr] <= req_i.prev_wdata;
    rsp_o.meta <= meta_mem[req_i.meta_raddr];
    rsp_o.next <= next_mem[req_i.next_raddr];
    rsp_o.prev <= prev_mem[req_i.prev_raddr];
  end

  assign clr_busy_o = clr_busy_q;

endmodule

// File: hdl/bpa_core.sv
// ----------------------------------------------------------------------------
// bpa_core: allocation sequencer
// Sizing, list walk, split and merge loops over one list-update unit
// (remove, push front, push back) and one split step.
// ----------------------------------------------------------------------------
module bpa_core import bpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  in_t      in_i,
  output logic     idle_o,
  output logic     done_o,
  input  logic     res_ready_i,
  output out_t     res_o,
  output mem_req_t req_o,
  input  mem_rsp_t rsp_i,
  input  logic     clr_busy_i
);

  localparam logic [SW-1:0] S_IDLE    = 6'd0;
  localparam logic [SW-1:0] S_DONE    = 6'd1;
  localparam logic [SW-1:0] S_A_SIZE  = 6'd2;
  localparam logic [SW-1:0] S_A_J     = 6'd3;
  localparam logic [SW-1:0] S_A_SGL   = 6'd4;
  localparam logic [SW-1:0] S_TB0     = 6'd5;
  localparam logic [SW-1:0] S_TB2     = 6'd6;
  localparam logic [SW-1:0] S_TB3     = 6'd7;
  localparam logic [SW-1:0] S_P1      = 6'd8;
  localparam logic [SW-1:0] S_P2      = 6'd9;
  localparam logic [SW-1:0] S_P_SPLIT = 6'd10;
  localparam logic [SW-1:0] S_P_TBRET = 6'd11;
  localparam logic [SW-1:0] S_P_SPQ   = 6'd12;
  localparam logic [SW-1:0] S_P_GOTQ  = 6'd13;
  localparam logic [SW-1:0] S_P3      = 6'd14;
  localparam logic [SW-1:0] S_P4      = 6'd15;
  localparam logic [SW-1:0] S_P5      = 6'd16;
  localparam logic [SW-1:0] S_F0      = 6'd17;
  localparam logic [SW-1:0] S_F1      = 6'd18;
  localparam logic [SW-1:0] S_FM0     = 6'd19;
  localparam logic [SW-1:0] S_FM1     = 6'd20;
  localparam logic [SW-1:0] S_FM2     = 6'd21;
  localparam logic [SW-1:0] S_FM3     = 6'd22;
  localparam logic [SW-1:0] S_FM4     = 6'd23;
  localparam logic [SW-1:0] S_FEND    = 6'd24;
  localparam logic [SW-1:0] S_R0      = 6'd25;
  localparam logic [SW-1:0] S_R1      = 6'd26;
  localparam logic [SW-1:0] S_LF0     = 6'd27;
  localparam logic [SW-1:0] S_LF1     = 6'd28;
  localparam logic [SW-1:0] S_LB0     = 6'd29;
  localparam logic [SW-1:0] S_LB1     = 6'd30;
  localparam logic [SW-1:0] S_SP0     = 6'd31;
  localparam logic [SW-1:0] S_SP1     = 6'd32;
  localparam logic [SW-1:0] S_SPRET   = 6'd33;

  logic [SW-1:0] st_q, st_d, ret_q, ret_d, sret_q, sret_d;
  logic [PW-1:0] p_q, p_d, q_q, q_d, b_q, b_d, lp_q, lp_d, sp_q, sp_d;
  logic [PW-1:0] cnt_q, cnt_d, rest_q, rest_d, total_q, total_d;
  logic [OW-1:0] lo_q, lo_d, so_q, so_d, n_q, n_d, m_q, m_d, i_q, i_d;
  logic [OW-1:0] cur_q, cur_d, tgt_q, tgt_d, qord_q, qord_d;
  logic          pair_q, pair_d, tbok_q, tbok_d;
  status_e       status_q, status_d;
  logic [AW-1:0] start_q, start_d;
  logic [OW-1:0] depth_q, depth_d;
  logic [AW-1:0] stack_q [NUM_ORDERS];
  logic [AW-1:0] stack_d [NUM_ORDERS];
  logic [PW-1:0] head_q [NUM_ORDERS];
  logic [PW-1:0] head_d [NUM_ORDERS];
  logic [PW-1:0] tail_q [NUM_ORDERS];
  logic [PW-1:0] tail_d [NUM_ORDERS];

  logic [PW-1:0] s_n, sz, sf, pg_lo, pg_hi, lk_h, lk_t, lk_nx, lk_pv;
  logic [SW-1:0] tb_ret;

  assign s_n    = PW'(1) << n_q;
  assign sz     = PW'(1) << i_q;
  assign sf     = PW'(1) << rsp_i.meta.order;
  assign pg_lo  = (p_q < b_q) ? p_q : b_q;
  assign pg_hi  = (p_q < b_q) ? b_q : p_q;
  assign lk_h   = head_q[lo_q];
  assign lk_t   = tail_q[lo_q];
  assign lk_nx  = rsp_i.next;
  assign lk_pv  = rsp_i.prev;
  assign tb_ret = pair_q ? S_P_TBRET : S_A_SGL;

  // sequencer next state and store requests
  always_comb begin
    st_d = st_q;  ret_d = ret_q;  sret_d = sret_q;
    p_d = p_q;  q_d = q_q;  b_d = b_q;  lp_d = lp_q;  sp_d = sp_q;
    cnt_d = cnt_q;  rest_d = rest_q;  total_d = total_q;
    lo_d = lo_q;  so_d = so_q;  n_d = n_q;  m_d = m_q;  i_d = i_q;
    cur_d = cur_q;  tgt_d = tgt_q;  qord_d = qord_q;
    pair_d = pair_q;  tbok_d = tbok_q;  status_d = status_q;  start_d = start_q;
    depth_d = depth_q;  stack_d = stack_q;  head_d = head_q;  tail_d = tail_q;
    req_o = '0;

    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          cnt_d    = (in_i.page_count == '0) ? PW'(1) : in_i.page_count;
          p_d      = {1'b0, in_i.page};
          depth_d  = '0;
          start_d  = '0;
          status_d = ST_OK;
          i_d      = '0;
          st_d     = in_i.action ? S_F0 : S_A_SIZE;
        end
      end

      // pick a single order or a pair
      S_A_SIZE: begin
        if (sz >= cnt_q) begin
          pair_d = 1'b0;  n_d = i_q;  tgt_d = i_q;  st_d = S_TB0;
        end else if (i_q != '0 && (sz + (sz >> 1)) >= cnt_q) begin
          pair_d = 1'b1;  n_d = i_q;  rest_d = cnt_q - sz;  m_d = '0;  st_d = S_A_J;
        end else if (i_q == ORD_MAX) begin
          status_d = ST_NOMEM;  st_d = S_DONE;
        end else begin
          i_d = i_q + OW'(1);
        end
      end

      S_A_J: begin
        if ((m_q + OW'(1)) < n_q && (PW'(1) << m_q) < rest_q) begin
          m_d = m_q + OW'(1);
        end else begin
          p_d  = head_q[n_q];
          st_d = S_P1;
        end
      end

      S_A_SGL: begin
        if (tbok_q) begin
          req_o.meta_we    = 1'b1;
          req_o.meta_waddr = p_q[AW-1:0];
          req_o.meta_wdata = '{kind: KIND_ALLOC, order: n_q};
          start_d          = p_q[AW-1:0];
        end else begin
          status_d = ST_NOMEM;
        end
        st_d = S_DONE;
      end

      // take the first block at or above the target order
      S_TB0: begin
        if (i_q > ORD_MAX) begin
          tbok_d = 1'b0;  st_d = tb_ret;
        end else if (head_q[i_q] < NIL) begin
          p_d = head_q[i_q];  lp_d = head_q[i_q];  lo_d = i_q;  cur_d = i_q;
          ret_d = S_TB2;  st_d = S_R0;
        end else begin
          i_d = i_q + OW'(1);
        end
      end

      S_TB2: begin
        if (cur_q > tgt_q) begin
          sp_d = p_q;  so_d = cur_q - OW'(1);  sret_d = S_TB3;  st_d = S_SP0;
        end else begin
          tbok_d = 1'b1;  st_d = tb_ret;
        end
      end

      S_TB3: begin
        cur_d = cur_q - OW'(1);
        st_d  = S_TB2;
      end

      // pair: walk the order list for a free upper neighbor
      S_P1: begin
        if (p_q >= NIL || (p_q & s_n) != '0) begin
          st_d = S_P_SPLIT;
        end else begin
          q_d              = p_q | s_n;
          req_o.meta_raddr = AW'(p_q | s_n);
          req_o.next_raddr = p_q[AW-1:0];
          st_d             = S_P2;
        end
      end

      S_P2: begin
        if (q_q < NIL && rsp_i.meta.kind == KIND_FREE && rsp_i.meta.order >= m_q) begin
          qord_d = rsp_i.meta.order;
          lp_d = p_q;  lo_d = n_q;  ret_d = S_P_GOTQ;  st_d = S_R0;
        end else begin
          p_d  = lk_nx;
          st_d = S_P1;
        end
      end

      S_P_SPLIT: begin
        if (n_q == ORD_MAX) begin
          status_d = ST_NOMEM;  st_d = S_DONE;
        end else begin
          tgt_d = n_q + OW'(1);  i_d = n_q + OW'(1);  st_d = S_TB0;
        end
      end

      S_P_TBRET: begin
        if (!tbok_q) begin
          status_d = ST_NOMEM;  st_d = S_DONE;
        end else begin
          sp_d = p_q;  so_d = n_q;  sret_d = S_P_SPQ;  st_d = S_SP0;
        end
      end

      S_P_SPQ: begin
        q_d = p_q | s_n;  qord_d = n_q;  st_d = S_P_GOTQ;
      end

      S_P_GOTQ: begin
        lp_d = q_q;  lo_d = qord_q;  ret_d = S_P3;  st_d = S_R0;
      end

      S_P3: begin
        req_o.meta_we    = 1'b1;
        req_o.meta_waddr = p_q[AW-1:0];
        req_o.meta_wdata = '{kind: KIND_PAIR, order: n_q};
        st_d             = S_P4;
      end

      S_P4: begin
        if (qord_q > m_q) begin
          sp_d = q_q;  so_d = qord_q - OW'(1);  sret_d = S_P5;  st_d = S_SP0;
        end else begin
          req_o.meta_we    = 1'b1;
          req_o.meta_waddr = q_q[AW-1:0];
          req_o.meta_wdata = '{kind: KIND_ALLOC, order: m_q};
          start_d          = p_q[AW-1:0];
          st_d             = S_DONE;
        end
      end

      S_P5: begin
        qord_d = qord_q - OW'(1);
        st_d   = S_P4;
      end

      // free: pair heads push onto the stack and free their tail first
      S_F0: begin
        if (p_q >= NIL) begin
          status_d = ST_NOT_HEAD;  st_d = S_FEND;
        end else begin
          req_o.meta_raddr = p_q[AW-1:0];
          st_d             = S_F1;
        end
      end

      S_F1: begin
        n_d = rsp_i.meta.order;
        case (rsp_i.meta.kind)
          KIND_PAIR: begin
            if ((p_q & sf) != '0) begin
              status_d = ST_BAD_PAIR;  st_d = S_FEND;
            end else begin
              req_o.meta_we      = 1'b1;
              req_o.meta_waddr   = p_q[AW-1:0];
              req_o.meta_wdata   = '{kind: KIND_ALLOC, order: rsp_i.meta.order};
              stack_d[depth_q]   = p_q[AW-1:0];
              depth_d            = depth_q + OW'(1);
              p_d                = p_q | sf;
              st_d               = S_F0;
            end
          end
          KIND_FREE: begin
            status_d = ST_DOUBLE;  st_d = S_FEND;
          end
          KIND_ALLOC, KIND_RESERVED: begin
            req_o.meta_we    = 1'b1;
            req_o.meta_waddr = p_q[AW-1:0];
            req_o.meta_wdata = '{kind: KIND_FREE, order: rsp_i.meta.order};
            lp_d = p_q;  lo_d = rsp_i.meta.order;  ret_d = S_FM0;
            status_d = ST_OK;
            st_d = ((p_q & sf) != '0) ? S_LB0 : S_LF0;
          end
          default: begin
            status_d = ST_NOT_HEAD;  st_d = S_FEND;
          end
        endcase
      end

      // merge with the buddy while it is a free block of the same order
      S_FM0: begin
        if (n_q < ORD_MAX && (p_q ^ s_n) < NIL) begin
          b_d              = p_q ^ s_n;
          req_o.meta_raddr = AW'(p_q ^ s_n);
          st_d             = S_FM1;
        end else begin
          st_d = S_FEND;
        end
      end

      S_FM1: begin
        if (rsp_i.meta.kind == KIND_FREE && rsp_i.meta.order == n_q) begin
          lp_d = pg_lo;  lo_d = n_q;  ret_d = S_FM2;  st_d = S_R0;
        end else begin
          st_d = S_FEND;
        end
      end

      S_FM2: begin
        lp_d = pg_hi;  lo_d = n_q;  ret_d = S_FM3;  st_d = S_R0;
      end

      S_FM3: begin
        req_o.meta_we    = 1'b1;
        req_o.meta_waddr = pg_hi[AW-1:0];
        req_o.meta_wdata = '{kind: KIND_NOT_HEAD, order: n_q};
        st_d             = S_FM4;
      end

      S_FM4: begin
        req_o.meta_we    = 1'b1;
        req_o.meta_waddr = pg_lo[AW-1:0];
        req_o.meta_wdata = '{kind: KIND_FREE, order: n_q + OW'(1)};
        n_d = n_q + OW'(1);  p_d = pg_lo;  lp_d = pg_lo;  lo_d = n_q + OW'(1);
        ret_d = S_FM0;
        st_d = ((pg_lo & (s_n << 1)) != '0) ? S_LB0 : S_LF0;
      end

      // nested results are dropped; pop the next pair head
      S_FEND: begin
        if (depth_q == '0) begin
          st_d = S_DONE;
        end else begin
          depth_d = depth_q - OW'(1);
          p_d     = {1'b0, stack_q[depth_q - OW'(1)]};
          st_d    = S_F0;
        end
      end

      S_DONE: begin
        if (res_ready_i) st_d = S_IDLE;
      end

      // list unit: unlink lp from list lo
      S_R0: begin
        req_o.next_raddr = lp_q[AW-1:0];
        req_o.prev_raddr = lp_q[AW-1:0];
        st_d             = S_R1;
      end

      S_R1: begin
        if (lk_pv < NIL) begin
          req_o.next_we = 1'b1;  req_o.next_waddr = lk_pv[AW-1:0];  req_o.next_wdata = lk_nx;
        end else begin
          head_d[lo_q] = lk_nx;
        end
        if (lk_nx < NIL) begin
          req_o.prev_we = 1'b1;  req_o.prev_waddr = lk_nx[AW-1:0];  req_o.prev_wdata = lk_pv;
        end else begin
          tail_d[lo_q] = lk_pv;
        end
        total_d = total_q - (PW'(1) << lo_q);
        st_d    = ret_q;
      end

      // list unit: push lp at the head
      S_LF0: begin
        req_o.prev_we = 1'b1;  req_o.prev_waddr = lp_q[AW-1:0];  req_o.prev_wdata = NIL;
        req_o.next_we = 1'b1;  req_o.next_waddr = lp_q[AW-1:0];  req_o.next_wdata = lk_h;
        if (lk_h < NIL) begin
          st_d = S_LF1;
        end else begin
          tail_d[lo_q] = lp_q;  head_d[lo_q] = lp_q;
          total_d = total_q + (PW'(1) << lo_q);
          st_d = ret_q;
        end
      end

      S_LF1: begin
        req_o.prev_we = 1'b1;  req_o.prev_waddr = lk_h[AW-1:0];  req_o.prev_wdata = lp_q;
        head_d[lo_q] = lp_q;
        total_d = total_q + (PW'(1) << lo_q);
        st_d = ret_q;
      end

      // list unit: push lp at the tail
      S_LB0: begin
        req_o.next_we = 1'b1;  req_o.next_waddr = lp_q[AW-1:0];  req_o.next_wdata = NIL;
        req_o.prev_we = 1'b1;  req_o.prev_waddr = lp_q[AW-1:0];  req_o.prev_wdata = lk_t;
        if (lk_t < NIL) begin
          st_d = S_LB1;
        end else begin
          head_d[lo_q] = lp_q;  tail_d[lo_q] = lp_q;
          total_d = total_q + (PW'(1) << lo_q);
          st_d = ret_q;
        end
      end

      S_LB1: begin
        req_o.next_we = 1'b1;  req_o.next_waddr = lk_t[AW-1:0];  req_o.next_wdata = lp_q;
        tail_d[lo_q] = lp_q;
        total_d = total_q + (PW'(1) << lo_q);
        st_d = ret_q;
      end

      // split step: halve sp, upper half to the tail of order so
      S_SP0: begin
        req_o.meta_we    = 1'b1;
        req_o.meta_waddr = sp_q[AW-1:0];
        req_o.meta_wdata = '{kind: KIND_FREE, order: so_q};
        st_d             = S_SP1;
      end

      S_SP1: begin
        req_o.meta_we    = 1'b1;
        req_o.meta_waddr = AW'(sp_q | (PW'(1) << so_q));
        req_o.meta_wdata = '{kind: KIND_FREE, order: so_q};
        lp_d = sp_q | (PW'(1) << so_q);  lo_d = so_q;  ret_d = S_SPRET;  st_d = S_LB0;
      end

      S_SPRET: st_d = sret_q;

      default: st_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      total_q <= '0;
      depth_q <= '0;
      for (int k = 0; k < NUM_ORDERS; k++) begin
        head_q[k] <= NIL;
        tail_q[k] <= NIL;
      end
    end else begin
      st_q    <= st_d;
      total_q <= total_d;
      depth_q <= depth_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d;  sret_q <= sret_d;
    p_q <= p_d;  q_q <= q_d;  b_q <= b_d;  lp_q <= lp_d;  sp_q <= sp_d;
    cnt_q <= cnt_d;  rest_q <= rest_d;
    lo_q <= lo_d;  so_q <= so_d;  n_q <= n_d;  m_q <= m_d;  i_q <= i_d;
    cur_q <= cur_d;  tgt_q <= tgt_d;  qord_q <= qord_d;
    pair_q <= pair_d;  tbok_q <= tbok_d;  status_q <= status_d;  start_q <= start_d;
    stack_q <= stack_d;
  end

  assign idle_o           = (st_q == S_IDLE) && !clr_busy_i;
  assign done_o           = (st_q == S_DONE);
  assign res_o.start_page = start_q;
  assign res_o.status     = status_q;
  assign res_o.free_pages = total_q;

endmodule

// File: hdl/buddy_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit: buddy page allocator, 4096 pages, orders 0-12
// Allocates page blocks (single orders or order pairs) and frees them with
// buddy merging; one result beat per request beat.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i): action 0 allocates
//   page_count pages, action 1 frees the block headed by page.
//   out channel (out_valid_o/out_ready_i/out_data_o): start page, status
//   and the number of free pages after the request.
//   One request is worked on at a time; in_ready_o is low meanwhile. An
//   allocate sizes orders, scans order lists, walks list entries and splits
//   blocks (a pair also does two unlinks); a free merges order by order and
//   handles each pair part in turn. The sequencer has a single list update
//   unit, which hits each link store at most once a cycle.
//   The result sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls with a result still held, the
//   sequencer holds its next result until the register drains.
//   Reset: all lists empty, free count zero, and a sweep marks every page
//   reserved; in_ready_o stays low during the sweep.
// ----------------------------------------------------------------------------
module buddy_page_allocator_unit import bpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  logic     clr_busy, core_idle, core_done, res_ready;
  out_t     core_res;
  logic     out_valid_q;
  out_t     out_q;

  bpa_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rsp_o      (mem_rsp),
    .clr_busy_o (clr_busy)
  );

  bpa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && core_idle),
    .in_i        (in_data_i),
    .idle_o      (core_idle),
    .done_o      (core_done),
    .res_ready_i (res_ready),
    .res_o       (core_res),
    .req_o       (mem_req),
    .rsp_i       (mem_rsp),
    .clr_busy_i  (clr_busy)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= core_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && core_done) out_q <= core_res;
  end

  assign in_ready_o  = core_idle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a taken request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while previous request in flight");

  // failed requests report start page zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK || out_data_o.start_page == '0))
    else $error("error result with nonzero start page");

  // free count never exceeds the page count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.free_pages <= 13'(NUM_PAGES)))
    else $error("free page count out of range");

endmodule
